### sv/lji_pkg.sv
package lji_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int RES_W     = 9;
  localparam int PIX_W     = 8;
  localparam int SEL_W     = 4;
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PRED_W    = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_SEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd2;

  // predictor codes
  localparam logic [SEL_W-1:0] PRED_A        = 4'd1;
  localparam logic [SEL_W-1:0] PRED_B        = 4'd2;
  localparam logic [SEL_W-1:0] PRED_C        = 4'd3;
  localparam logic [SEL_W-1:0] PRED_PLANE    = 4'd4;
  localparam logic [SEL_W-1:0] PRED_A_HALF   = 4'd5;
  localparam logic [SEL_W-1:0] PRED_B_HALF   = 4'd6;
  localparam logic [SEL_W-1:0] PRED_AVG      = 4'd7;
  localparam logic [SEL_W-1:0] PRED_MED      = 4'd8;

  localparam logic [SEL_W-1:0]  PRED_SEL_RST = PRED_A;
  localparam logic [SIZE_W-1:0] COLS_RST     = 11'd1024;
  localparam logic [SIZE_W-1:0] ROWS_RST     = 11'd1024;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic eor;
    logic eof;
  } pos_flags_t;

  // halving truncates toward zero
  function automatic logic signed [PRED_W-1:0] predict(
    input logic [SEL_W-1:0] sel,
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [PIX_W-1:0] c
  );
    logic signed [PRED_W-1:0] sa;
    logic signed [PRED_W-1:0] sb;
    logic signed [PRED_W-1:0] sc;
    logic [PIX_W-1:0]         mx;
    logic [PIX_W-1:0]         mn;
    logic signed [PRED_W-1:0] res;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    mx = (a > b) ? a : b;
    mn = (a > b) ? b : a;
    unique case (sel)
      PRED_A:      res = sa;
      PRED_B:      res = sb;
      PRED_C:      res = sc;
      PRED_PLANE:  res = sa + sb - sc;
      PRED_A_HALF: res = sa + (sb - sc) / 11'sd2;
      PRED_B_HALF: res = sb + (sa - sc) / 11'sd2;
      PRED_AVG:    res = (sa + sb) / 11'sd2;
      PRED_MED: begin
        if (c >= mx)      res = signed'({3'b000, mn});
        else if (c <= mn) res = signed'({3'b000, mx});
        else              res = sa + sb - sc;
      end
      default:     res = '0;
    endcase
    return res;
  endfunction

endpackage

### sv/lji_row_mem.sv
module lji_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read word while the consumer stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/lji_pos_ctr.sv
module lji_pos_ctr #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int CW       = 10,
  parameter int RW       = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [lji_pkg::SIZE_W-1:0]  cols_cfg,
  input  logic [lji_pkg::SIZE_W-1:0]  rows_cfg,
  output logic [CW-1:0]               col,
  output lji_pkg::pos_flags_t         flags
);
  import lji_pkg::*;

  localparam int SZA = (CW > RW) ? CW + 1 : RW + 1;
  localparam int SZW = (SZA > SIZE_W) ? SZA : SIZE_W;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [SZW-1:0] cols_ext, rows_ext, cols_lim, rows_lim;
  logic [SZW-1:0] col_inc, row_inc;
  logic           eor, eof;

  always_comb begin
    cols_ext = SZW'(cols_cfg);
    rows_ext = SZW'(rows_cfg);
    // clamp sizes into 1..MAX
    if (cols_ext == '0)                 cols_lim = SZW'(1);
    else if (cols_ext > SZW'(MAX_COLS)) cols_lim = SZW'(MAX_COLS);
    else                                cols_lim = cols_ext;
    if (rows_ext == '0)                 rows_lim = SZW'(1);
    else if (rows_ext > SZW'(MAX_ROWS)) rows_lim = SZW'(MAX_ROWS);
    else                                rows_lim = rows_ext;
    col_inc = SZW'(col_r) + SZW'(1);
    row_inc = SZW'(row_r) + SZW'(1);
    eor     = (col_inc >= cols_lim);
    eof     = eor && (row_inc >= rows_lim);
    col_nxt = eor ? '0 : col_inc[CW-1:0];
    if (!eor)     row_nxt = row_r;
    else if (eof) row_nxt = '0;
    else          row_nxt = row_inc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col             = col_r;
  assign flags.first_row = (row_r == '0);
  assign flags.first_col = (col_r == '0);
  assign flags.eor       = eor;
  assign flags.eof       = eof;

endmodule

### sv/lossless_jpeg_intra_reconstructor.sv
// Each accepted residual word is registered in the reconstruct stage and then in
// the output register. One pixel per cycle while out_stall is low; the row memory
// is read in the cycle before the add stage, and left_r feeds back the left pixel.
// Reset (rst_n, synchronous): clears counters, neighbor registers, valid flags and
// loads predictor select 1 and a 1024 by 1024 frame; row memory is not cleared.
module lossless_jpeg_intra_reconstructor #(
  parameter int MAX_COLS = lji_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lji_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [lji_pkg::RES_W-1:0] in_residual,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lji_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_end_of_row,
  output logic                          out_end_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lji_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lji_pkg::SIZE_W-1:0]    cfg_data
);
  import lji_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [SEL_W-1:0]  sel_r;
  logic [SIZE_W-1:0] cols_r;
  logic [SIZE_W-1:0] rows_r;

  logic              in_acc, out_free, s1_adv;
  logic [CW-1:0]     pos_col;
  pos_flags_t        pos_flags;

  logic                     s1_valid_r;
  logic signed [RES_W-1:0]  s1_res_r;
  logic [CW-1:0]            s1_col_r;
  pos_flags_t               s1_flags_r;
  logic                     fwd_r;
  logic [PIX_W-1:0]         fwd_pix_r;
  logic [PIX_W-1:0]         left_r;
  logic [PIX_W-1:0]         ul_r;

  logic                     out_valid_r;
  logic [PIX_W-1:0]         out_pixel_r;
  logic                     out_eor_r;
  logic                     out_eof_r;

  logic [PIX_W-1:0]         rd_data, above, a, b, c, px;
  logic signed [PRED_W-1:0] pred, sum;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r  <= PRED_SEL_RST;
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRED_SEL:   sel_r  <= cfg_data[SEL_W-1:0];
        CFG_FRAME_COLS: cols_r <= cfg_data;
        CFG_FRAME_ROWS: rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  lji_pos_ctr #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (in_acc),
    .cols_cfg (cols_r),
    .rows_cfg (rows_r),
    .col      (pos_col),
    .flags    (pos_flags)
  );

  lji_row_mem #(
    .DEPTH   (MAX_COLS),
    .AW      (CW),
    .DW      (PIX_W)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (px),
    .rd_en   (in_acc),
    .rd_addr (pos_col),
    .rd_data (rd_data)
  );

  // reconstruct stage
  always_comb begin
    above = fwd_r ? fwd_pix_r : rd_data;
    a     = s1_flags_r.first_col ? '0 : left_r;
    b     = s1_flags_r.first_row ? '0 : above;
    c     = (s1_flags_r.first_row || s1_flags_r.first_col) ? '0 : ul_r;
    pred  = predict(sel_r, a, b, c);
    sum   = PRED_W'(s1_res_r) + pred;
    px    = sum[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      left_r     <= '0;
      ul_r       <= '0;
    end else begin
      if (in_acc)      s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) begin
        left_r <= px;
        ul_r   <= b;
      end
    end
  end

  // stage payload; forward the word being written when it hits the read address
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r   <= in_residual;
      s1_col_r   <= pos_col;
      s1_flags_r <= pos_flags;
      fwd_r      <= s1_adv && (s1_col_r == pos_col);
      fwd_pix_r  <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel_r <= px;
      out_eor_r   <= s1_flags_r.eor;
      out_eof_r   <= s1_flags_r.eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_valid_r) |-> s1_adv)
    else $error("word accepted while stage holds a stalled pixel");

  a_retire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("retired pixel did not reach the output register");

  a_eof_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_eof_r || out_eor_r))
    else $error("end of frame without end of row");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_res_r)))
    else $error("stalled stage changed");

endmodule
